>>> rtl/core/laea_pkg.sv
// Shared types, constants and helper functions for the equal-area projection core.
// Used by every module under rtl/core; depends on nothing else.
package laea_pkg;

    // Field widths.
    localparam int ANGLE_BITS    = 32;
    localparam int OUT_FRAC_BITS = 29;
    localparam int OUT_W         = OUT_FRAC_BITS + 3;

    // Internal fixed point: Q.30 fractions.
    localparam int WF       = 30;
    localparam int CORDIC_N = 30;

    // Shifts that bring an angle to a 32-bit turn fraction.
    localparam int TURN_UP = (ANGLE_BITS >= 32) ? 0 : 32 - ANGLE_BITS;
    localparam int TURN_DN = (ANGLE_BITS >= 32) ? ANGLE_BITS - 32 : 0;

    // Final conversion shifts from Q.30 to the output fraction.
    localparam int OUT_LSH = (OUT_FRAC_BITS >= WF) ? OUT_FRAC_BITS - WF : 0;
    localparam int OUT_RSH = (OUT_FRAC_BITS >= WF) ? 0 : WF - OUT_FRAC_BITS;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_LONGITUDE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_LATITUDE  = 8'd1;

    // CORDIC gain compensation, 0.60725293500888 in Q1.30.
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef logic signed [31:0] trig_t;

    // One input request.
    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] longitude;
        logic signed [ANGLE_BITS-1:0] latitude;
        logic                         last;
    } request_t;

    // One result.
    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic                    antipode;
        logic                    last_out;
    } result_t;

    // Sines and cosines of one request, handed from front end to back end.
    typedef struct packed {
        trig_t a;   // sin(center latitude)
        trig_t b;   // cos(center latitude)
        trig_t c;   // sin(latitude)
        trig_t d;   // cos(latitude)
        trig_t e;   // sin(dlon)
        trig_t f;   // cos(dlon)
        logic  last;
    } trig_set_t;

    // Arctangent of 2^-i in 32-bit turns.
    function automatic logic signed [33:0] atan_turn(input int i);
        logic signed [33:0] r;
        case (i)
            0:  r = 34'sh020000000;
            1:  r = 34'sh012E4051E;
            2:  r = 34'sh009FB385B;
            3:  r = 34'sh0051111D4;
            4:  r = 34'sh0028B0D43;
            5:  r = 34'sh00145D7E1;
            6:  r = 34'sh000A2F61E;
            7:  r = 34'sh000517C55;
            8:  r = 34'sh00028BE53;
            9:  r = 34'sh000145F2F;
            10: r = 34'sh0000A2F98;
            11: r = 34'sh0000517CC;
            12: r = 34'sh000028BE6;
            13: r = 34'sh0000145F3;
            14: r = 34'sh00000A2F9;
            15: r = 34'sh00000517C;
            16: r = 34'sh0000028BE;
            17: r = 34'sh00000145F;
            18: r = 34'sh000000A2F;
            19: r = 34'sh000000517;
            20: r = 34'sh00000028B;
            21: r = 34'sh000000145;
            22: r = 34'sh0000000A2;
            23: r = 34'sh000000051;
            24: r = 34'sh000000028;
            25: r = 34'sh000000014;
            26: r = 34'sh00000000A;
            27: r = 34'sh000000005;
            28: r = 34'sh000000002;
            29: r = 34'sh000000001;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    // Bring a binary angle to a 32-bit turn fraction.
    function automatic logic [31:0] to_turn32(input logic [ANGLE_BITS-1:0] u);
        logic [63:0] w;
        w = 64'(u);
        if (ANGLE_BITS >= 32) begin
            return 32'(w >> TURN_DN);
        end
        return 32'(w << TURN_UP);
    endfunction

endpackage

>>> rtl/core/laea_cordic.sv
// Pipelined rotation-mode CORDIC giving sine and cosine of a 32-bit turn angle.
// Depends on laea_pkg for the arctangent table and gain constant.
module laea_cordic
    import laea_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] angle,
    output trig_t       sin_val,
    output trig_t       cos_val
);

    logic signed [33:0] x_reg [0:CORDIC_N];
    logic signed [33:0] y_reg [0:CORDIC_N];
    logic signed [33:0] z_reg [0:CORDIC_N];
    logic               flip_reg [0:CORDIC_N];
    logic signed [33:0] z_in;
    logic               flip_in;
    trig_t              sin_reg;
    trig_t              cos_reg;

    // Fold angles beyond a quarter turn by a half turn and remember to negate.
    always_comb
    begin
        z_in    = 34'(signed'(angle));
        flip_in = 1'b0;
        if (z_in > 34'sd1073741824 || z_in < -34'sd1073741824) begin
            flip_in = 1'b1;
            if (z_in > 34'sd0) begin
                z_in = z_in - 34'sd2147483648;
            end else begin
                z_in = z_in + 34'sd2147483648;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= CORDIC_GAIN;
        y_reg[0]    <= 34'sd0;
        z_reg[0]    <= z_in;
        flip_reg[0] <= flip_in;
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < CORDIC_N; i++) begin : g_stage
        always_ff @(posedge clk)
        begin
            flip_reg[i+1] <= flip_reg[i];
            if (z_reg[i] >= 34'sd0) begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - atan_turn(i);
            end else begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + atan_turn(i);
            end
        end
    end

    // Undo the fold.
    always_ff @(posedge clk)
    begin
        if (flip_reg[CORDIC_N]) begin
            sin_reg <= 32'(-y_reg[CORDIC_N]);
            cos_reg <= 32'(-x_reg[CORDIC_N]);
        end else begin
            sin_reg <= 32'(y_reg[CORDIC_N]);
            cos_reg <= 32'(x_reg[CORDIC_N]);
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

>>> rtl/core/laea_front.sv
// Front end: holds the center registers, takes requests and computes all sines and cosines.
// Depends on laea_pkg and laea_cordic.
module laea_front
    import laea_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  request_t               request,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ANGLE_BITS-1:0]  cfg_data,
    output logic                   push,
    output trig_set_t              push_data
);

    localparam int LAT = CORDIC_N + 2;

    logic [ANGLE_BITS-1:0] center_lon_reg;
    logic [ANGLE_BITS-1:0] center_lat_reg;
    logic [31:0]           dlon_reg;
    logic [31:0]           clat_reg;
    logic [31:0]           lat_reg;
    logic                  in_valid_reg;
    logic                  in_last_reg;
    logic                  valid_reg [0:LAT-1];
    logic                  last_reg  [0:LAT-1];
    trig_t                 a_w, b_w, c_w, d_w, e_w, f_w;

    // Center registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            center_lon_reg <= '0;
            center_lat_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == CFG_CENTER_LONGITUDE) begin
                center_lon_reg <= cfg_data;
            end
            if (cfg_index == CFG_CENTER_LATITUDE) begin
                center_lat_reg <= cfg_data;
            end
        end
    end

    // Input register: longitude difference wraps modulo a full turn.
    always_ff @(posedge clk)
    begin
        dlon_reg    <= to_turn32(request.longitude) - to_turn32(center_lon_reg);
        clat_reg    <= to_turn32(center_lat_reg);
        lat_reg     <= to_turn32(request.latitude);
        in_last_reg <= request.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= accept;
        end
    end

    laea_cordic u_cordic_center (.clk(clk), .angle(clat_reg), .sin_val(a_w), .cos_val(b_w));
    laea_cordic u_cordic_lat    (.clk(clk), .angle(lat_reg),  .sin_val(c_w), .cos_val(d_w));
    laea_cordic u_cordic_dlon   (.clk(clk), .angle(dlon_reg), .sin_val(e_w), .cos_val(f_w));

    // Valid and last travel alongside the CORDIC pipelines.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            valid_reg[0] <= in_valid_reg;
            for (int i = 1; i < LAT; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg[0] <= in_last_reg;
        for (int i = 1; i < LAT; i++) begin
            last_reg[i] <= last_reg[i-1];
        end
    end

    assign push           = valid_reg[LAT-1];
    assign push_data.a    = a_w;
    assign push_data.b    = b_w;
    assign push_data.c    = c_w;
    assign push_data.d    = d_w;
    assign push_data.e    = e_w;
    assign push_data.f    = f_w;
    assign push_data.last = last_reg[LAT-1];

endmodule

>>> rtl/core/laea_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on laea_pkg for the entry type.
module laea_queue
    import laea_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  trig_set_t push_data,
    input  logic      pop,
    output logic      head_valid,
    output trig_set_t head_data,
    output logic      full
);

    trig_set_t   mem_reg [0:1];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Occupancy.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    assign head_valid = (count_reg != 2'd0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign full       = (count_reg == 2'd2);

endmodule

>>> rtl/core/laea_back.sv
// Back end: products, denominator, pipelined divide and square root, scaling and output.
// Depends on laea_pkg.
module laea_back
    import laea_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  trig_set_t trig,
    output logic      result_valid,
    output result_t   result
);

    localparam int DIV_N  = 63;
    localparam int SQ_N   = 32;
    localparam int SIDE_N = DIV_N + SQ_N + 1;

    typedef struct packed {
        logic [3:0]  sh;
        logic        xs;
        logic [32:0] xa;
        logic        ys;
        logic [32:0] ya;
        logic        anti;
        logic        last;
    } side_t;

    // Q1.30 product rounded half up.
    function automatic trig_t fmul(input trig_t p, input trig_t q);
        logic signed [63:0] pr;
        pr = 64'(p) * 64'(q);
        return 32'((pr + 64'sd536870912) >>> WF);
    endfunction

    // Stage 1 and 2 products.
    logic               v1_reg, v2_reg, v3_reg;
    logic               l1_reg, l2_reg, l3_reg;
    trig_t              a1_reg, b1_reg, df1_reg, ac1_reg, de1_reg, bc1_reg;
    trig_t              ac2_reg, de2_reg, bc2_reg, bdf2_reg, adf2_reg;
    logic signed [33:0] den3_reg, xn3_reg, yn3_reg;
    logic               anti3_reg;

    always_ff @(posedge clk)
    begin
        a1_reg   <= trig.a;
        b1_reg   <= trig.b;
        df1_reg  <= fmul(trig.d, trig.f);
        ac1_reg  <= fmul(trig.a, trig.c);
        de1_reg  <= fmul(trig.d, trig.e);
        bc1_reg  <= fmul(trig.b, trig.c);
        l1_reg   <= trig.last;

        ac2_reg  <= ac1_reg;
        de2_reg  <= de1_reg;
        bc2_reg  <= bc1_reg;
        bdf2_reg <= fmul(b1_reg, df1_reg);
        adf2_reg <= fmul(a1_reg, df1_reg);
        l2_reg   <= l1_reg;

        den3_reg  <= 34'sd1073741824 + 34'(ac2_reg) + 34'(bdf2_reg);
        anti3_reg <= (34'sd1073741824 + 34'(ac2_reg) + 34'(bdf2_reg)) <= 34'sd0;
        xn3_reg   <= 34'(de2_reg);
        yn3_reg   <= 34'(bc2_reg) - 34'(adf2_reg);
        l3_reg    <= l2_reg;
    end

    // Normalize the denominator by an even shift to at least 2^29.
    logic [31:0] nd0, nd1, nd2, nd3, nd4;
    logic [3:0]  sh_w;
    side_t       side_w;

    always_comb
    begin
        nd0  = anti3_reg ? 32'd536870912 : den3_reg[31:0];
        sh_w = 4'd0;
        nd1  = nd0;
        if (nd0 < 32'd32768) begin
            nd1  = nd0 << 16;
            sh_w = sh_w + 4'd8;
        end
        nd2 = nd1;
        if (nd1 < 32'd8388608) begin
            nd2  = nd1 << 8;
            sh_w = sh_w + 4'd4;
        end
        nd3 = nd2;
        if (nd2 < 32'd134217728) begin
            nd3  = nd2 << 4;
            sh_w = sh_w + 4'd2;
        end
        nd4 = nd3;
        if (nd3 < 32'd536870912) begin
            nd4  = nd3 << 2;
            sh_w = sh_w + 4'd1;
        end
        side_w.sh   = sh_w;
        side_w.xs   = xn3_reg[33];
        side_w.xa   = xn3_reg[33] ? 33'(-xn3_reg) : 33'(xn3_reg);
        side_w.ys   = yn3_reg[33];
        side_w.ya   = yn3_reg[33] ? 33'(-yn3_reg) : 33'(yn3_reg);
        side_w.anti = anti3_reg;
        side_w.last = l3_reg;
    end

    // Divider and root pipelines with the sideband beside them.
    logic [31:0] dv_rem_reg [0:DIV_N];
    logic [62:0] dv_q_reg   [0:DIV_N];
    logic [31:0] dv_dn_reg  [0:DIV_N];
    logic [63:0] sq_v_reg   [0:SQ_N];
    logic [63:0] sq_res_reg [0:SQ_N];
    side_t       side_reg   [0:SIDE_N];
    logic        pv_reg     [0:SIDE_N];

    always_ff @(posedge clk)
    begin
        dv_rem_reg[0] <= 32'd268435456;
        dv_q_reg[0]   <= '0;
        dv_dn_reg[0]  <= nd4;
        side_reg[0]   <= side_w;
    end

    // Restoring division of 2^91 by the normalized denominator, one bit a stage.
    for (genvar j = 0; j < DIV_N; j++) begin : g_div
        logic [32:0] r2;
        assign r2 = {dv_rem_reg[j], 1'b0};
        always_ff @(posedge clk)
        begin
            dv_dn_reg[j+1] <= dv_dn_reg[j];
            if (r2 >= {1'b0, dv_dn_reg[j]}) begin
                dv_rem_reg[j+1] <= 32'(r2 - {1'b0, dv_dn_reg[j]});
                dv_q_reg[j+1]   <= {dv_q_reg[j][61:0], 1'b1};
            end else begin
                dv_rem_reg[j+1] <= r2[31:0];
                dv_q_reg[j+1]   <= {dv_q_reg[j][61:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sq_v_reg[0]   <= 64'(dv_q_reg[DIV_N]);
        sq_res_reg[0] <= '0;
    end

    // Integer square root, one result bit a stage.
    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        localparam logic [63:0] ONE_BIT = 64'd1 << (2 * (SQ_N - 1 - k));
        logic [63:0] trial;
        assign trial = sq_res_reg[k] + ONE_BIT;
        always_ff @(posedge clk)
        begin
            if (sq_v_reg[k] >= trial) begin
                sq_v_reg[k+1]   <= sq_v_reg[k] - trial;
                sq_res_reg[k+1] <= (sq_res_reg[k] >> 1) + ONE_BIT;
            end else begin
                sq_v_reg[k+1]   <= sq_v_reg[k];
                sq_res_reg[k+1] <= sq_res_reg[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 1; i <= SIDE_N; i++) begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // Valid bits of every stage from the queue head to the output.
    logic vm_reg, vr_reg, vo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int i = 0; i <= SIDE_N; i++) begin
                pv_reg[i] <= 1'b0;
            end
            vm_reg <= 1'b0;
            vr_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            v1_reg    <= take;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            pv_reg[0] <= v3_reg;
            for (int i = 1; i <= SIDE_N; i++) begin
                pv_reg[i] <= pv_reg[i-1];
            end
            vm_reg <= pv_reg[SIDE_N];
            vr_reg <= vm_reg;
            vo_reg <= vr_reg;
        end
    end

    // Scale by k: the root times each magnitude, then the shift by half the even normalization shift.
    logic [64:0] mx_reg, my_reg;
    side_t       sm_reg, sr_reg;
    logic [31:0] rx_reg, ry_reg;

    always_ff @(posedge clk)
    begin
        mx_reg <= 65'(sq_res_reg[SQ_N][31:0]) * 65'(side_reg[SIDE_N].xa);
        my_reg <= 65'(sq_res_reg[SQ_N][31:0]) * 65'(side_reg[SIDE_N].ya);
        sm_reg <= side_reg[SIDE_N];
    end

    // Round half up and saturate magnitudes to 2.0.
    logic [79:0] tx_w, ty_w;

    always_comb
    begin
        tx_w = ((80'(mx_reg) << sm_reg.sh) + 80'd536870912) >> WF;
        ty_w = ((80'(my_reg) << sm_reg.sh) + 80'd536870912) >> WF;
    end

    always_ff @(posedge clk)
    begin
        rx_reg <= (tx_w > 80'd2147483648) ? 32'd2147483648 : tx_w[31:0];
        ry_reg <= (ty_w > 80'd2147483648) ? 32'd2147483648 : ty_w[31:0];
        sr_reg <= sm_reg;
    end

    // Apply signs and convert to the output format.
    logic signed [63:0] sx_w, sy_w, ox_w, oy_w;
    result_t            res_reg;

    always_comb
    begin
        sx_w = sr_reg.xs ? -64'(rx_reg) : 64'(rx_reg);
        sy_w = sr_reg.ys ? -64'(ry_reg) : 64'(ry_reg);
        if (OUT_FRAC_BITS >= WF) begin
            ox_w = sx_w <<< OUT_LSH;
            oy_w = sy_w <<< OUT_LSH;
        end else begin
            ox_w = (sx_w + ((64'sd1 <<< OUT_RSH) >>> 1)) >>> OUT_RSH;
            oy_w = (sy_w + ((64'sd1 <<< OUT_RSH) >>> 1)) >>> OUT_RSH;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg.x        <= sr_reg.anti ? '0 : ox_w[OUT_W-1:0];
        res_reg.y        <= sr_reg.anti ? '0 : oy_w[OUT_W-1:0];
        res_reg.antipode <= sr_reg.anti;
        res_reg.last_out <= sr_reg.last;
    end

    assign result_valid = vo_reg;
    assign result       = res_reg;

endmodule

>>> rtl/core/laea_forward_projection.sv
// Top level of the Lambert azimuthal equal-area forward projection core.
// Depends on laea_pkg, laea_front, laea_queue and laea_back.
//
//  channel   signals                               handshake
//  request   start, busy, request                  taken when start && !busy
//  config    cfg_valid, cfg_ready, cfg_index,      written when cfg_valid && cfg_ready
//            cfg_data
//  result    result_valid, result                  one-cycle strobe, no back-pressure
//
// One request is taken every cycle that start is high and busy is low; the path from a
// request to its result is mostly the 63-stage divider and the 32-stage square root.
// Reset clears the center registers and all valid bits; there is no clearing pass.
// Since results cannot be held off, the back end drains the queue every cycle
// and busy stays low in operation.
module laea_forward_projection
    import laea_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  request_t               request,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ANGLE_BITS-1:0]  cfg_data,
    output logic                   result_valid,
    output result_t                result
);

    logic      accept;
    logic      push;
    trig_set_t push_data;
    logic      head_valid;
    trig_set_t head_data;
    logic      full;

    assign accept    = start && !full;
    assign busy      = full;
    assign cfg_ready = 1'b1;

    laea_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .request   (request),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .push_data (push_data)
    );

    laea_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (head_valid),
        .head_valid (head_valid),
        .head_data  (head_data),
        .full       (full)
    );

    laea_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (head_valid),
        .trig         (head_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

>>> tb/sv/laea_forward_projection_test.sv
// Self-checking testbench for the equal-area forward projection core.
// Depends on laea_pkg and the laea_forward_projection RTL; predicts every result itself.
module laea_forward_projection_test;
    import laea_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 8'd2;
    localparam longint Q_ONE = 64'sd1 << WF;
    localparam int     SETTLE_CYCLES = 160;

    logic clk;
    logic rst_n;
    logic start = 1'b0;
    logic busy;
    request_t request = '0;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [ANGLE_BITS-1:0] cfg_data;
    logic result_valid;
    result_t result;

    // Predictor copy of the center registers.
    logic [ANGLE_BITS-1:0] center_lon;
    logic [ANGLE_BITS-1:0] center_lat;

    request_t pending_points[$];
    result_t  projected[$];
    int gap_left = 0;
    int gap_max = 0;
    int failures = 0;

    laea_forward_projection dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Arctangent of 2^-i in 32-bit turns.
    function automatic longint atan_step(input int i);
        longint tbl[30] = '{
            'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
            'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
            'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2F9,
            'h0000517C, 'h000028BE, 'h0000145F, 'h00000A2F, 'h00000517,
            'h0000028B, 'h00000145, 'h000000A2, 'h00000051, 'h00000028,
            'h00000014, 'h0000000A, 'h00000005, 'h00000002, 'h00000001};
        return tbl[i];
    endfunction

    function automatic logic [31:0] turn_fraction(input logic [ANGLE_BITS-1:0] u);
        logic [63:0] w;
        w = 64'(u);
        if (ANGLE_BITS >= 32)
            return 32'(w >> TURN_DN);
        return 32'(w << TURN_UP);
    endfunction

    // Rotation CORDIC giving sine and cosine in Q1.30.
    function automatic void cordic_sin_cos(input logic [31:0] ang, output longint s,
                                           output longint c);
        longint z;
        longint xr;
        longint yr;
        longint t;
        bit flip;
        z = longint'($signed(ang));
        xr = 652032874;
        yr = 0;
        flip = 1'b0;
        if (z > (64'sd1 <<< 30) || z < -(64'sd1 <<< 30))
        begin
            z += (z > 0) ? -(64'sd1 <<< 31) : (64'sd1 <<< 31);
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_N; i++)
        begin
            if (z >= 0)
            begin
                t = xr - (yr >>> i);
                yr = yr + (xr >>> i);
                z -= atan_step(i);
            end
            else
            begin
                t = xr + (yr >>> i);
                yr = yr - (xr >>> i);
                z += atan_step(i);
            end
            xr = t;
        end
        s = flip ? -yr : yr;
        c = flip ? -xr : xr;
    endfunction

    function automatic longint qmul(input longint p, input longint q);
        return (p * q + (Q_ONE >>> 1)) >>> WF;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Scale by k, saturating at +-2.0.
    function automatic longint scale_by_k(input longint k, input longint v);
        logic [63:0] av;
        logic [63:0] r;
        av = (v < 0) ? -v : v;
        if (av != 0 && k > ((64'd1 << 62) / av))
            r = 2 * Q_ONE;
        else
        begin
            r = (k * av + (64'd1 << (WF - 1))) >> WF;
            if (r > 2 * Q_ONE)
                r = 2 * Q_ONE;
        end
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [OUT_W-1:0] to_output(input longint r);
        longint v;
        if (r > 2 * Q_ONE)
            r = 2 * Q_ONE;
        if (r < -2 * Q_ONE)
            r = -2 * Q_ONE;
        if (OUT_FRAC_BITS >= WF)
            v = r <<< OUT_LSH;
        else
            v = (r + (64'sd1 <<< (OUT_RSH - 1))) >>> OUT_RSH;
        return v[OUT_W-1:0];
    endfunction

    // Expected projection of one point about the current center.
    function automatic result_t project_point(input request_t p);
        result_t o;
        longint a, b, c, d, e, f, df, den, dn, q, rem, k;
        logic [31:0] dlon;
        int s;
        dlon = turn_fraction(p.longitude) - turn_fraction(center_lon);
        cordic_sin_cos(turn_fraction(center_lat), a, b);
        cordic_sin_cos(turn_fraction(p.latitude), c, d);
        cordic_sin_cos(dlon, e, f);
        df = qmul(d, f);
        den = Q_ONE + qmul(a, c) + qmul(b, df);
        o = '0;
        o.last_out = p.last;
        if (den <= 0)
        begin
            o.antipode = 1'b1;
            return o;
        end
        dn = den;
        s = 0;
        while (dn < (64'sd1 <<< 29))
        begin
            dn <<= 2;
            s += 2;
        end
        q = (64'sd1 <<< 62) / dn;
        rem = (64'sd1 <<< 62) % dn;
        for (int i = 0; i < 29; i++)
        begin
            rem <<= 1;
            q <<= 1;
            if (rem >= dn)
            begin
                rem -= dn;
                q++;
            end
        end
        k = longint'(int_sqrt(q)) << (s / 2);
        o.x = to_output(scale_by_k(k, qmul(d, e)));
        o.y = to_output(scale_by_k(k, qmul(b, c) - qmul(a, df)));
        return o;
    endfunction

    // Request driver: presents queued points, with a random pause after each.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
                projected.push_back(project_point(request));
            if (!start || !busy)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end
                else if (pending_points.size() > 0)
                begin
                    request <= pending_points.pop_front();
                    start <= 1'b1;
                    gap_left <= $urandom_range(0, gap_max);
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Result monitor: compares each strobe with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (projected.size() == 0)
            begin
                $error("unexpected result x=%0d y=%0d", $signed(result.x), $signed(result.y));
                failures++;
            end
            else
            begin
                result_t want;
                want = projected.pop_front();
                if (result.x !== want.x)
                begin
                    $error("x expected %0d got %0d", $signed(want.x), $signed(result.x));
                    failures++;
                end
                if (result.y !== want.y)
                begin
                    $error("y expected %0d got %0d", $signed(want.y), $signed(result.y));
                    failures++;
                end
                if (result.antipode !== want.antipode)
                begin
                    $error("antipode expected %0b got %0b", want.antipode, result.antipode);
                    failures++;
                end
                if (result.last_out !== want.last_out)
                begin
                    $error("last_out expected %0b got %0b", want.last_out, result.last_out);
                    failures++;
                end
            end
        end
    end

    // One register write through the configuration channel.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_CENTER_LONGITUDE: center_lon = val;
            CFG_CENTER_LATITUDE:  center_lat = val;
            default: ;
        endcase
    endtask

    task automatic queue_point(input logic [31:0] lon, input logic [31:0] lat, input logic lst);
        request_t p;
        p.longitude = lon;
        p.latitude = lat;
        p.last = lst;
        pending_points.push_back(p);
    endtask

    // Random points: mostly valid latitudes, some near the antipode, some raw angles.
    task automatic queue_random_points(input int n);
        logic [31:0] lat;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0: queue_point($urandom, $urandom, 1'($urandom_range(0, 1)));
                1, 2: queue_point(center_lon + 32'h8000_0000 + $urandom_range(0, 64) - 32,
                                  -center_lat + $urandom_range(0, 64) - 32,
                                  1'($urandom_range(0, 1)));
                default:
                begin
                    lat = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
                    queue_point($urandom, lat, 1'($urandom_range(0, 1)));
                end
            endcase
        end
    endtask

    // Let every queued point through and every result come back.
    task automatic drain;
        while (pending_points.size() > 0 || start || projected.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] lons[6];
        logic [31:0] lats[6];
        lons = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'hC000_0000, 32'h0};
        lats = '{32'h0, 32'h4000_0000, 32'hC000_0000, 32'h1555_5555, 32'hF000_0000,
                 32'h7FFF_FFFF};
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        center_lon = '0;
        center_lat = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed points about the reset center, no pauses.
        gap_max = 0;
        queue_point(32'h0, 32'h0, 1'b0);
        queue_point(32'h8000_0000, 32'h0, 1'b1);
        queue_point(32'h7FFF_FFFF, 32'h0, 1'b0);
        queue_point(32'h8000_0010, 32'h0000_0008, 1'b0);
        queue_point(32'h0, 32'h4000_0000, 1'b1);
        queue_point(32'h0, 32'hC000_0000, 1'b0);
        queue_point(32'h4000_0000, 32'h0, 1'b0);
        queue_point(32'hC000_0000, 32'h2000_0000, 1'b1);
        queue_point(32'h1000_0000, 32'h7FFF_FFFF, 1'b0);
        queue_point(32'hF000_0000, 32'h8000_0000, 1'b1);
        queue_point(32'hFFFF_FFFF, 32'h5000_0000, 1'b0);
        queue_point(32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
        queue_point(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        queue_point(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
        queue_random_points(60);
        drain();

        // Each phase moves the center, then streams its antipode, the center point and random points.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_register(CFG_CENTER_LONGITUDE, lons[ph] ^ ((ph == 5) ? $urandom : 32'h0));
            write_register(CFG_CENTER_LATITUDE, lats[ph]);
            if (ph == 3)
                write_register(CFG_UNUSED_INDEX, $urandom);
            gap_max = (ph % 2 == 0) ? 7 : 0;
            queue_point(center_lon + 32'h8000_0000, -center_lat, 1'b1);
            queue_point(center_lon, center_lat, 1'b0);
            queue_random_points(75);
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("PASS laea_forward_projection");
        else
            $display("FAIL laea_forward_projection");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("FAIL laea_forward_projection");
        $finish;
    end

endmodule
